// File: sv/pid_with_deadband_feedforward_unit_assert.svh
// Assertion macros for the PID unit.
// Included by the controller and the top level; no other dependencies.
`ifndef PID_WITH_DEADBAND_FEEDFORWARD_UNIT_ASSERT_SVH
`define PID_WITH_DEADBAND_FEEDFORWARD_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define PID_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define PID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: sv/pidff_pkg.sv
// Shared types and constants for the PID unit.
// No dependencies.
package pidff_pkg;
   localparam int unsigned QShift = 16;

   typedef enum logic [3:0] {
      CSR_GAIN_P    = 4'd0,
      CSR_GAIN_I    = 4'd1,
      CSR_GAIN_D    = 4'd2,
      CSR_DEAD_BAND = 4'd3
   } csr_index_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;    // latch input beat, compute error
      logic clear;   // zero state
      logic integ;   // update integral
      logic div_start;
      logic div_step;
      logic deriv;   // finish derivative
      logic mul_p;   // load multiplier operands: p, i, d term (low half first)
      logic mul_i;
      logic mul_d;
      logic mul_hi;  // switch multiplier to the high half of the operand
      logic acc;     // add product into sum
      logic finish;  // clamp sum into output
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;
endpackage

// File: sv/pidff_if.sv
// Valid/ready channel interfaces for the PID unit.
// Depends on nothing.
interface pidff_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] setpoint_angle;
   logic [31:0] measured_angle;
   logic [31:0] feed_forward;
   logic [23:0] elapsed_time;
   modport source (output valid, command, setpoint_angle, measured_angle, feed_forward,
                   elapsed_time, input ready);
   modport sink (input valid, command, setpoint_angle, measured_angle, feed_forward,
                 elapsed_time, output ready);
endinterface

interface pidff_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] torque;
   logic        saturated;
   modport source (output valid, torque, saturated, input ready);
   modport sink (input valid, torque, saturated, output ready);
endinterface

interface pidff_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: sv/pidff_datapath.sv
// PID datapath: registers, error/deadband, restoring divider, shared multiplier.
// Depends on pidff_pkg.
module pidff_datapath import pidff_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              csr_we,
   input  logic [3:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  logic [31:0]       in_target,
   input  logic [31:0]       in_measured,
   input  logic [31:0]       in_ff,
   input  logic [23:0]       in_dt,
   output logic [31:0]       torque,
   output logic              saturated
);
   logic signed [31:0] gain_p_ff, gain_p_in, gain_i_ff, gain_i_in, gain_d_ff, gain_d_in;
   logic [30:0]        band_ff, band_in;
   logic signed [47:0] integ_ff, integ_in;
   logic signed [31:0] last_ff, last_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] ff_ff, ff_in;
   logic [23:0]        dt_ff, dt_in;
   logic signed [31:0] deriv_ff, deriv_in;
   logic signed [63:0] sum_ff, sum_in;
   logic               sat_ff, sat_in;
   logic signed [31:0] torque_ff, torque_in;
   // divider: magnitude of 49-bit dividend, shifted one bit per step
   logic [48:0]        quo_ff, quo_in;
   logic [24:0]        rem_ff, rem_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   // multiplier operands; x is taken in two 24-bit halves
   logic signed [31:0] mg_ff, mg_in;
   logic signed [47:0] mx_ff, mx_in;
   logic               half_ff, half_in;
   logic signed [24:0] mpart;
   logic signed [56:0] prod;

   logic signed [32:0] diff;
   logic signed [31:0] ecl;
   logic [31:0]        emag;
   logic signed [55:0] eprod;
   logic signed [48:0] isum;
   logic signed [32:0] ddiff;
   logic [48:0]        dmag;
   logic [24:0]        trial;
   logic signed [49:0] qs;
   logic signed [63:0] tsum;

   always_comb begin
      diff  = $signed({in_target[31], in_target}) - $signed({in_measured[31], in_measured});
      if (diff > 33'sd2147483647) ecl = 32'h7fffffff;
      else if (diff < -33'sd2147483648) ecl = 32'h80000000;
      else ecl = diff[31:0];
      emag  = ecl[31] ? 32'(-ecl) : ecl;
      eprod = 56'(err_ff) * $signed({32'd0, dt_ff});
      isum  = 49'(integ_ff) + 49'(eprod >>> QShift);
      ddiff = 33'(err_ff) - 33'(last_ff);
      dmag  = ddiff[32] ? 49'(-ddiff) << QShift : 49'(ddiff) << QShift;
      trial = {rem_ff[23:0], quo_ff[48]} - {1'b0, dt_ff};
      qs    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      // high half signed, low half unsigned
      mpart = half_ff ? $signed({mx_ff[47], mx_ff[47:24]}) : $signed({1'b0, mx_ff[23:0]});
      prod  = mg_ff * mpart;
      tsum  = sum_ff + 64'(ff_ff);
   end

   always_comb begin
      gain_p_in = gain_p_ff; gain_i_in = gain_i_ff; gain_d_in = gain_d_ff;
      band_in = band_ff; integ_in = integ_ff; last_in = last_ff;
      err_in = err_ff; ff_in = ff_ff; dt_in = dt_ff; deriv_in = deriv_ff;
      sum_in = sum_ff; sat_in = sat_ff; torque_in = torque_ff;
      quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff; neg_in = neg_ff;
      mg_in = mg_ff; mx_in = mx_ff; half_in = half_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:    gain_p_in = csr_data;
            CSR_GAIN_I:    gain_i_in = csr_data;
            CSR_GAIN_D:    gain_d_in = csr_data;
            CSR_DEAD_BAND: band_in = csr_data[30:0];
            default: ;
         endcase
      end
      if (cmd.clear) begin
         integ_in = '0; last_in = '0; torque_in = '0; sat_in = 1'b0;
      end
      if (cmd.load) begin
         err_in = (emag < {1'b0, band_ff}) ? '0 : ecl;
         ff_in = in_ff; dt_in = in_dt; sat_in = 1'b0; sum_in = '0;
      end
      // saturating integral
      if (cmd.integ) begin
         if (isum > 49'sh0_7fff_ffff_ffff) begin
            integ_in = 48'sh7fff_ffff_ffff; sat_in = 1'b1;
         end else if (isum < -49'sh0_8000_0000_0000) begin
            integ_in = 48'sh8000_0000_0000; sat_in = 1'b1;
         end else integ_in = isum[47:0];
      end
      if (cmd.div_start) begin
         quo_in = dmag; rem_in = '0; cnt_in = 6'd49; neg_in = ddiff[32];
      end
      // one restoring step
      if (cmd.div_step) begin
         if (!trial[24]) begin
            rem_in = trial; quo_in = {quo_ff[47:0], 1'b1};
         end else begin
            rem_in = {rem_ff[23:0], quo_ff[48]}; quo_in = {quo_ff[47:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end
      if (cmd.deriv) begin
         if (dt_ff == '0) deriv_in = '0;
         else if (qs > 50'sd2147483647) deriv_in = 32'h7fffffff;
         else if (qs < -50'sd2147483648) deriv_in = 32'h80000000;
         else deriv_in = qs[31:0];
         last_in = err_ff;
      end
      if (cmd.mul_p) begin mg_in = gain_p_ff; mx_in = 48'(err_ff); half_in = 1'b0; end
      if (cmd.mul_i) begin mg_in = gain_i_ff; mx_in = integ_ff; half_in = 1'b0; end
      if (cmd.mul_d) begin mg_in = gain_d_ff; mx_in = 48'(deriv_ff); half_in = 1'b0; end
      if (cmd.mul_hi) half_in = 1'b1;
      // low half: floor(g*xl / 2^16); high half: g*xh * 2^(24-16), exact
      if (cmd.acc) begin
         if (half_ff) sum_in = sum_ff + (64'(prod) <<< (24 - QShift));
         else sum_in = sum_ff + 64'(prod >>> QShift);
      end
      if (cmd.finish) begin
         if (tsum > 64'sd2147483647) begin
            torque_in = 32'h7fffffff; sat_in = 1'b1;
         end else if (tsum < -64'sd2147483648) begin
            torque_in = 32'h80000000; sat_in = 1'b1;
         end else torque_in = tsum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= 32'sd65536; gain_i_ff <= '0; gain_d_ff <= '0;
         band_ff <= 31'd19661; integ_ff <= '0; last_ff <= '0; cnt_ff <= '0;
      end else begin
         gain_p_ff <= gain_p_in; gain_i_ff <= gain_i_in; gain_d_ff <= gain_d_in;
         band_ff <= band_in; integ_ff <= integ_in; last_ff <= last_in; cnt_ff <= cnt_in;
      end
      err_ff <= err_in; ff_ff <= ff_in; dt_ff <= dt_in; deriv_ff <= deriv_in;
      sum_ff <= sum_in; sat_ff <= sat_in; torque_ff <= torque_in;
      quo_ff <= quo_in; rem_ff <= rem_in; neg_ff <= neg_in; mg_ff <= mg_in; mx_ff <= mx_in;
      half_ff <= half_in;
   end

   assign status.div_done = (cnt_ff == 6'd0);
   assign torque = torque_ff;
   assign saturated = sat_ff;
endmodule

// File: sv/pidff_ctrl.sv
// PID sequencer: one-hot state machine issuing datapath commands.
// Depends on pidff_pkg and the assertion header.
`include "pid_with_deadband_feedforward_unit_assert.svh"
module pidff_ctrl import pidff_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic       in_command,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_INTEG = 12'b000000000010,
      S_DIV   = 12'b000000000100,
      S_DERIV = 12'b000000001000,
      S_MP    = 12'b000000010000,
      S_MPH   = 12'b000000100000,
      S_MI    = 12'b000001000000,
      S_MIH   = 12'b000010000000,
      S_MD    = 12'b000100000000,
      S_MDH   = 12'b001000000000,
      S_FIN   = 12'b010000000000,
      S_OUT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept;

   // a new beat may enter once the previous result is taken or being taken
   assign in_ready = (state_ff == S_IDLE) && (!out_valid_ff || out_ready);
   assign accept = in_valid && in_ready;

   // each gain term takes two multiplier passes: low half, then high half
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      out_valid_in = out_valid_ff && !out_ready;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            if (in_command) begin cmd.clear = 1'b1; out_valid_in = 1'b1; end
            else begin cmd.load = 1'b1; state_in = S_INTEG; end
         end
         S_INTEG: begin cmd.integ = 1'b1; cmd.div_start = 1'b1; state_in = S_DIV; end
         S_DIV: if (status.div_done) state_in = S_DERIV; else cmd.div_step = 1'b1;
         S_DERIV: begin cmd.deriv = 1'b1; cmd.mul_p = 1'b1; state_in = S_MP; end
         S_MP: begin cmd.acc = 1'b1; cmd.mul_hi = 1'b1; state_in = S_MPH; end
         S_MPH: begin cmd.acc = 1'b1; cmd.mul_i = 1'b1; state_in = S_MI; end
         S_MI: begin cmd.acc = 1'b1; cmd.mul_hi = 1'b1; state_in = S_MIH; end
         S_MIH: begin cmd.acc = 1'b1; cmd.mul_d = 1'b1; state_in = S_MD; end
         S_MD: begin cmd.acc = 1'b1; cmd.mul_hi = 1'b1; state_in = S_MDH; end
         S_MDH: begin cmd.acc = 1'b1; state_in = S_FIN; end
         S_FIN: begin cmd.finish = 1'b1; state_in = S_OUT; end
         S_OUT: begin out_valid_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;

   `PID_ASSERT_IMP(a_ready_idle, clock, reset, in_ready, state_ff == S_IDLE)
   `PID_ASSERT_NEXT(a_step_starts, clock, reset, accept && !in_command, state_ff == S_INTEG)
   `PID_ASSERT_NEXT(a_clear_result, clock, reset, accept && in_command, out_valid_ff)
   `PID_ASSERT_IMP(a_one_cmd_mul, clock, reset, 1'b1, $onehot0({cmd.mul_p, cmd.mul_i, cmd.mul_d}))
endmodule

// File: sv/pid_with_deadband_feedforward_unit.sv
// Top level of the PID unit: channels, sequencer and datapath.
// Depends on pidff_pkg, pidff_if, pidff_ctrl, pidff_datapath.
// One beat at a time: a clear command yields its result in the cycle after
// acceptance; a control step yields its result after the integral update,
// the 49-step bit-serial divider for the derivative, six passes through the
// shared 32x25 multiplier (each gain term takes its operand in two halves)
// and the final clamp. A new beat is accepted as soon as the result register
// is free or being taken.
// Configuration writes are always accepted; write only while idle.
`include "pid_with_deadband_feedforward_unit_assert.svh"
module pid_with_deadband_feedforward_unit import pidff_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pidff_req_if.sink   req,
   pidff_rsp_if.source rsp,
   pidff_csr_if.sink   csr
);
   cmd_type    cmd;
   status_type status;
   logic       req_accept;

   assign csr.ready = 1'b1;
   assign req_accept = req.valid && req.ready;

   pidff_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_command(req.command), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .status, .cmd
   );

   pidff_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .csr_we(csr.valid), .csr_index(csr.index), .csr_data(csr.data),
      .in_target(req.setpoint_angle), .in_measured(req.measured_angle),
      .in_ff(req.feed_forward), .in_dt(req.elapsed_time),
      .torque(rsp.torque), .saturated(rsp.saturated)
   );

   `PID_ASSERT_NEXT(a_clear_zero, clock, reset, req_accept && req.command, rsp.torque == '0)
   `PID_ASSERT_IMP(a_no_accept_busy, clock, reset, req_accept, !rsp.valid || rsp.ready)
   `PID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.torque))
endmodule

// File: tb/sv/tb_pidff_pkg.sv
// Testbench-side helpers for the PID unit: beat structs.
// Depends on pidff_pkg only.
package tb_pidff_pkg;
   import pidff_pkg::*;

   typedef struct packed {
      logic        command;
      logic [31:0] setpoint_angle;
      logic [31:0] measured_angle;
      logic [31:0] feed_forward;
      logic [23:0] elapsed_time;
   } step_beat_type;

   typedef struct packed {
      logic [31:0] torque;
      logic        saturated;
   } torque_beat_type;
endpackage

// File: tb/sv/tb_top.sv
// Self-checking testbench for pid_with_deadband_feedforward_unit.
// Depends on pidff_pkg, pidff_if, tb_pidff_pkg and the unit's RTL.
module tb_top;
   import pidff_pkg::*;
   import tb_pidff_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint I32_MAX = 64'sd2147483647;
   localparam longint I32_MIN = -64'sd2147483648;
   localparam longint I48_MAX = 64'sd140737488355327;
   localparam longint I48_MIN = -64'sd140737488355328;
   localparam int     CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   pidff_req_if req ();
   pidff_rsp_if rsp ();
   pidff_csr_if csr ();

   pid_with_deadband_feedforward_unit u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   // predictor copy of registers and loop state
   longint kp, ki, kd, band;
   longint integ_acc, prev_err;
   torque_beat_type torque_q[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   int  rsp_idle_pct = 31;
   int  req_idle_pct = 31;
   int  hold_rsp = 0;

   function automatic longint clip(longint v, longint lo, longint hi, ref bit hit);
      if (v > hi) begin
         hit = 1; return hi;
      end
      if (v < lo) begin
         hit = 1; return lo;
      end
      return v;
   endfunction

   // exact floor(g * x / 2^16) via split of x
   function automatic longint gain_mul(longint g, longint x);
      longint hi, lo;
      hi = x >>> 16;
      lo = x - (hi <<< 16);
      return g * hi + ((g * lo) >>> 16);
   endfunction

   function automatic torque_beat_type pid_step(step_beat_type b);
      torque_beat_type r;
      bit sat, dummy;
      longint e, mag, deriv, sum, dt;
      sat = 0;
      dummy = 0;
      if (b.command) begin
         integ_acc = 0;
         prev_err = 0;
         r.torque = '0;
         r.saturated = 1'b0;
         return r;
      end
      dt = longint'(b.elapsed_time);
      e = clip(longint'($signed(b.setpoint_angle)) - longint'($signed(b.measured_angle)),
               I32_MIN, I32_MAX, dummy);
      mag = (e < 0) ? -e : e;
      if (mag < band) e = 0;
      integ_acc = clip(integ_acc + ((e * dt) >>> 16), I48_MIN, I48_MAX, sat);
      if (dt > 0) deriv = clip(((e - prev_err) * 65536) / dt, I32_MIN, I32_MAX, dummy);
      else deriv = 0;
      prev_err = e;
      sum = gain_mul(kp, e) + gain_mul(ki, integ_acc) + gain_mul(kd, deriv)
          + longint'($signed(b.feed_forward));
      sum = clip(sum, I32_MIN, I32_MAX, sat);
      r.torque = sum[31:0];
      r.saturated = sat;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // cycle limit and result-side readiness
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout");
         $display("Test completed with failures");
         $finish;
      end
      if (reset) rsp.ready <= 1'b0;
      else if (hold_rsp > 0) begin
         rsp.ready <= 1'b0;
         hold_rsp <= hold_rsp - 1;
      end else rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      torque_beat_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (torque_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp.torque, 32'h0);
         end else begin
            want = torque_q.pop_front();
            if (rsp.torque !== want.torque)
               report_mismatch("torque", rsp.torque, want.torque);
            if (rsp.saturated !== want.saturated)
               report_mismatch("saturated", {31'd0, rsp.saturated}, {31'd0, want.saturated});
         end
      end
   end

   // valid stays up after a beat; the next call either idles or offers the next beat
   task automatic send_step(step_beat_type b);
      if ($urandom_range(99) < req_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct) @(posedge clock);
      end
      req.valid <= 1'b1;
      {req.command, req.setpoint_angle, req.measured_angle, req.feed_forward,
       req.elapsed_time} <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      torque_q.push_back(pid_step(b));
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      case (idx)
         CSR_GAIN_P:    kp = longint'($signed(val));
         CSR_GAIN_I:    ki = longint'($signed(val));
         CSR_GAIN_D:    kd = longint'($signed(val));
         CSR_DEAD_BAND: band = longint'(val[30:0]);
         default: ;
      endcase
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (torque_q.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   function automatic step_beat_type mk(bit c, logic [31:0] t, logic [31:0] m,
                                        logic [31:0] f, logic [23:0] dt);
      step_beat_type b;
      b.command = c; b.setpoint_angle = t; b.measured_angle = m;
      b.feed_forward = f; b.elapsed_time = dt;
      return b;
   endfunction

   // random beat: mostly moderate angles near the deadband, some full range
   function automatic step_beat_type rand_step();
      step_beat_type b;
      b.command = ($urandom_range(19) == 0);
      b.setpoint_angle = $urandom;
      b.measured_angle = ($urandom_range(3) == 0) ? $urandom
                       : b.setpoint_angle - ($urandom_range(80000) - 40000);
      b.feed_forward = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000) - 100000;
      case ($urandom_range(3))
         0: b.elapsed_time = 24'd0;
         1: b.elapsed_time = 24'($urandom);
         default: b.elapsed_time = 24'($urandom_range(4000));
      endcase
      return b;
   endfunction

   task automatic test_defaults();
      send_step(mk(0, 32'h0001_0000, 32'h0, 32'h0, 24'd655));
      send_step(mk(0, 32'd19660, 32'h0, 32'h5, 24'd655));
      send_step(mk(0, 32'h0, 32'd19661, 32'h0, 24'd0));
      send_step(mk(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 24'hff_ffff));
      send_step(mk(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 24'h00_0001));
      send_step(mk(1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 24'hff_ffff));
      drain();
   endtask

   task automatic test_full_gains();
      write_csr(CSR_GAIN_P, 32'h7fff_ffff);
      write_csr(CSR_GAIN_I, 32'h8000_0000);
      write_csr(CSR_GAIN_D, 32'hffff_ffff);
      write_csr(CSR_DEAD_BAND, 32'h0);
      // drive integral toward its clip, then exercise derivative extremes
      repeat (6) send_step(mk(0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 24'hff_ffff));
      send_step(mk(0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 24'h1));
      send_step(mk(0, 32'h1, 32'h0, 32'h0, 24'h0));
      send_step(mk(1, 32'h0, 32'h0, 32'h0, 24'h0));
      send_step(mk(0, 32'h0, 32'h0, 32'h7fff_ffff, 24'h1));
      drain();
      write_csr(CSR_DEAD_BAND, 32'hffff_ffff);
      send_step(mk(0, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 24'h10));
      drain();
   endtask

   task automatic test_random(int n);
      repeat (n) send_step(rand_step());
   endtask

   task automatic test_backpressure();
      // receiver stalls while the sender keeps offering beats
      fork
         hold_rsp = 400;
      join
      req_idle_pct = 0;
      repeat (10) send_step(rand_step());
      req_idle_pct = 31;
      drain();
   endtask

   initial begin
      req.valid = 1'b0; req.command = 1'b0; req.setpoint_angle = '0;
      req.measured_angle = '0; req.feed_forward = '0; req.elapsed_time = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.index = CSR_GAIN_P; csr.data = '0;
      kp = 65536; ki = 0; kd = 0; band = 19661; integ_acc = 0; prev_err = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_full_gains();

      // moderate gains, random content
      write_csr(CSR_GAIN_P, 32'h0002_8000);
      write_csr(CSR_GAIN_I, 32'h0000_4000);
      write_csr(CSR_GAIN_D, 32'hffff_c000);
      write_csr(CSR_DEAD_BAND, 32'd19661);
      test_random(300);
      drain();

      // no idling stretch
      req_idle_pct = 0; rsp_idle_pct = 0;
      test_random(200);
      drain();
      req_idle_pct = 31; rsp_idle_pct = 31;

      test_backpressure();

      write_csr(CSR_GAIN_P, $urandom);
      write_csr(CSR_GAIN_I, $urandom);
      write_csr(CSR_GAIN_D, $urandom);
      write_csr(CSR_DEAD_BAND, $urandom);
      test_random(250);
      drain();

      write_csr(CSR_GAIN_P, 32'h8000_0000);
      write_csr(CSR_GAIN_I, 32'h7fff_ffff);
      write_csr(CSR_GAIN_D, 32'h7fff_ffff);
      write_csr(CSR_DEAD_BAND, 32'h7fff_ffff);
      test_random(250);
      drain();

      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
